@@ hdl/svpwm_pkg.sv @@
// ============================================================================
// svpwm_pkg
// Shared constants and types for the SVPWM duty calculation pipeline.
// ============================================================================
package svpwm_pkg;

    // Default field geometry
    localparam int VOLT_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Compare register width and reset value
    localparam int              CMP_W     = 16;
    localparam logic [CMP_W-1:0] CMP_RESET = 16'd5999;

    // sqrt(3) in Q28, and the Q28 scale shift of the alpha term
    localparam int               SQRT3_FRAC = 28;
    localparam logic [28:0]      SQRT3_Q28  = 29'd464943848;

    // Divider lanes
    localparam int NUM_LANES = 3;
    localparam int LANE_X    = 0;
    localparam int LANE_Y    = 1;
    localparam int LANE_Z    = 2;

    localparam int SECTOR_W = 3;

    typedef enum logic [SECTOR_W-1:0] {
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5,
        SECTOR_6 = 3'd6
    } sector_t;

endpackage

@@ hdl/svpwm_duty_calc_unit.sv @@
// ============================================================================
// svpwm_duty_calc_unit
// Seven-segment SVPWM duty calculator: alpha/beta and bus in, three compare
// values and the sector out.
// ============================================================================
// One item enters per clock unless a stall at the output has backed up to
// the input. Each item passes three front stages that form the X/Y/Z
// numerators and divider operands, a restoring divider of FRAC_BITS + 3
// stages at one quotient bit each for all three terms in parallel, and four
// back stages that saturate, pick the sector, build the on-times, scale by
// compare_max and clamp. Every stage holds its own valid bit, so a stall at
// the output only backs up as far as there are full stages. compare_max is
// written through the cfg channel, which is always ready; write it only
// while the pipeline is empty.
module svpwm_duty_calc_unit
    import svpwm_pkg::*;
#(
    parameter int VOLT_WIDTH = VOLT_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CMP_W-1:0]             cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VOLT_WIDTH-1:0] v_alpha,
    input  logic signed [VOLT_WIDTH-1:0] v_beta,
    input  logic [VOLT_WIDTH-1:0]        bus_voltage,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [CMP_W-1:0]             compare_a,
    output logic [CMP_W-1:0]             compare_b,
    output logic [CMP_W-1:0]             compare_c,
    output logic [SECTOR_W-1:0]          sector
);

    localparam int VW    = VOLT_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int QB    = FB + 3;          // quotient bits before saturation
    localparam int QW    = FB + 4;          // Q3.FB signed width
    localparam int TW    = FB + 6;          // on-time width
    localparam int NUM_W = VW + 31;         // signed numerator width
    localparam int MAG_W = VW + 30;         // numerator magnitude width
    localparam int DW    = VW + FB + 3;     // dividend width
    localparam int SH1   = SQRT3_FRAC - FB; // X denominator shift
    localparam int SH2   = SH1 + 1;         // Y/Z denominator shift
    localparam int PW    = TW - 1 + CMP_W;  // scaled product width
    localparam int CW    = PW - FB;

    localparam logic signed [29:0] SQRT3_S = {1'b0, SQRT3_Q28};

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] cmax_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmax_reg <= CMP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cmax_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // handshake chain
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic s1_rdy, s2_rdy, s3_rdy, p1_rdy, p2_rdy, p3_rdy, p4_rdy;
    logic div_in_ready, div_out_valid;

    assign p4_rdy   = !p4_valid_reg || out_ready;
    assign p3_rdy   = !p3_valid_reg || p4_rdy;
    assign p2_rdy   = !p2_valid_reg || p3_rdy;
    assign p1_rdy   = !p1_valid_reg || p2_rdy;
    assign s3_rdy   = !s3_valid_reg || div_in_ready;
    assign s2_rdy   = !s2_valid_reg || s3_rdy;
    assign s1_rdy   = !s1_valid_reg || s2_rdy;
    assign in_ready = s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy) s1_valid_reg <= in_valid;
            if (s2_rdy) s2_valid_reg <= s1_valid_reg;
            if (s3_rdy) s3_valid_reg <= s2_valid_reg;
            if (p1_rdy) p1_valid_reg <= div_out_valid;
            if (p2_rdy) p2_valid_reg <= p1_valid_reg;
            if (p3_rdy) p3_valid_reg <= p2_valid_reg;
            if (p4_rdy) p4_valid_reg <= p3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // S1: 3*alpha, sqrt3*beta, bus fixup
    // ------------------------------------------------------------------
    logic signed [VW+1:0]  s1_a3_reg,    s1_a3_next;
    logic signed [VW+29:0] s1_bprod_reg, s1_bprod_next;
    logic [VW-1:0]         s1_bus_reg,   s1_bus_next;

    always_comb
    begin
        s1_a3_next    = $signed({v_alpha[VW-1], v_alpha, 1'b0})
                      + $signed({{2{v_alpha[VW-1]}}, v_alpha});
        s1_bprod_next = v_beta * SQRT3_S;
        // zero bus is taken as one
        s1_bus_next   = (bus_voltage == '0) ? VW'(1) : bus_voltage;
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && in_valid)
        begin
            s1_a3_reg    <= s1_a3_next;
            s1_bprod_reg <= s1_bprod_next;
            s1_bus_reg   <= s1_bus_next;
        end
    end

    // ------------------------------------------------------------------
    // S2: numerators of X, Y, Z
    // ------------------------------------------------------------------
    logic [NUM_LANES-1:0][NUM_W-1:0] s2_num_reg, s2_num_next;
    logic [VW-1:0]                   s2_bus_reg;

    always_comb
    begin
        logic signed [NUM_W-1:0] anum;
        logic signed [NUM_W-1:0] bnum;
        anum = NUM_W'(s1_a3_reg) <<< SQRT3_FRAC;
        bnum = NUM_W'(s1_bprod_reg);
        s2_num_next[LANE_X] = bnum;
        s2_num_next[LANE_Y] = bnum + anum;
        s2_num_next[LANE_Z] = bnum - anum;
    end

    always_ff @(posedge clk)
    begin
        if (s2_rdy && s1_valid_reg)
        begin
            s2_num_reg <= s2_num_next;
            s2_bus_reg <= s1_bus_reg;
        end
    end

    // ------------------------------------------------------------------
    // S3: sign/magnitude split, denominator shift, overflow check
    // ------------------------------------------------------------------
    logic [NUM_LANES-1:0][VW-1:0] s3_rem_reg,  s3_rem_next;
    logic [NUM_LANES-1:0][QB-1:0] s3_lowq_reg, s3_lowq_next;
    logic [NUM_LANES-1:0]         s3_neg_reg,  s3_neg_next;
    logic [NUM_LANES-1:0]         s3_ovf_reg,  s3_ovf_next;
    logic [VW-1:0]                s3_bus_reg;

    always_comb
    begin
        logic signed [NUM_W-1:0] num;
        logic [NUM_W-1:0]        mag;
        logic [MAG_W-1:0]        shifted;
        logic [DW-1:0]           dvd;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            num     = $signed(s2_num_reg[l]);
            s3_neg_next[l] = num[NUM_W-1];
            mag     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            // trunc(n / (bus << s)) == floor(floor(|n| >> s) / bus)
            shifted = mag[MAG_W-1:0] >> ((l == LANE_X) ? SH1 : SH2);
            dvd     = shifted[DW-1:0];
            s3_rem_next[l]  = dvd[DW-1:QB];
            s3_lowq_next[l] = dvd[QB-1:0];
            s3_ovf_next[l]  = (dvd[DW-1:QB] >= s2_bus_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_rdy && s2_valid_reg)
        begin
            s3_rem_reg  <= s3_rem_next;
            s3_lowq_reg <= s3_lowq_next;
            s3_neg_reg  <= s3_neg_next;
            s3_ovf_reg  <= s3_ovf_next;
            s3_bus_reg  <= s2_bus_reg;
        end
    end

    // ------------------------------------------------------------------
    // divider
    // ------------------------------------------------------------------
    logic [NUM_LANES-1:0][QB-1:0] div_quo;
    logic [NUM_LANES-1:0]         div_neg;
    logic [NUM_LANES-1:0]         div_ovf;

    svpwm_divider #(
        .VW (VW),
        .QB (QB)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_ready  (div_in_ready),
        .in_rem    (s3_rem_reg),
        .in_lowq   (s3_lowq_reg),
        .in_neg    (s3_neg_reg),
        .in_ovf    (s3_ovf_reg),
        .in_bus    (s3_bus_reg),
        .out_valid (div_out_valid),
        .out_ready (p1_rdy),
        .out_quo   (div_quo),
        .out_neg   (div_neg),
        .out_ovf   (div_ovf)
    );

    // ------------------------------------------------------------------
    // P1: saturate to Q3.FB, sector from the sign tree
    // ------------------------------------------------------------------
    logic [NUM_LANES-1:0][QW-1:0] p1_xyz_reg, p1_xyz_next;
    sector_t                      p1_sector_reg, p1_sector_next;

    always_comb
    begin
        logic signed [QW-1:0] qs;
        logic signed [QW-1:0] xv;
        logic signed [QW-1:0] yv;
        logic signed [QW-1:0] zv;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            qs = $signed({1'b0, div_quo[l]});
            if (div_ovf[l])
            begin
                p1_xyz_next[l] = div_neg[l] ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
            end
            else
            begin
                p1_xyz_next[l] = div_neg[l] ? QW'(-qs) : QW'(qs);
            end
        end
        xv = $signed(p1_xyz_next[LANE_X]);
        yv = $signed(p1_xyz_next[LANE_Y]);
        zv = $signed(p1_xyz_next[LANE_Z]);
        if (yv < 0)
        begin
            if (zv < 0)
                p1_sector_next = SECTOR_5;
            else
                p1_sector_next = (xv < 0) ? SECTOR_4 : SECTOR_3;
        end
        else
        begin
            if (zv > 0)
                p1_sector_next = SECTOR_2;
            else
                p1_sector_next = (xv < 0) ? SECTOR_6 : SECTOR_1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_rdy && div_out_valid)
        begin
            p1_xyz_reg    <= p1_xyz_next;
            p1_sector_reg <= p1_sector_next;
        end
    end

    // ------------------------------------------------------------------
    // P2: phase on-times
    // ------------------------------------------------------------------
    function automatic logic signed [TW-1:0] half_trunc(input logic signed [TW-1:0] d);
        logic signed [TW-1:0] adj;
        // halve toward zero
        adj = $signed({{(TW-1){1'b0}}, d[TW-1]});
        return (d + adj) >>> 1;
    endfunction

    logic signed [TW-1:0] p2_ta_reg, p2_tb_reg, p2_tc_reg;
    logic signed [TW-1:0] p2_ta_next, p2_tb_next, p2_tc_next;
    sector_t              p2_sector_reg;

    always_comb
    begin
        logic signed [TW-1:0] half;
        logic signed [TW-1:0] x;
        logic signed [TW-1:0] y;
        logic signed [TW-1:0] z;
        half = $signed(TW'(1) << (FB - 1));
        x    = TW'($signed(p1_xyz_reg[LANE_X]));
        y    = TW'($signed(p1_xyz_reg[LANE_Y]));
        z    = TW'($signed(p1_xyz_reg[LANE_Z]));
        unique case (p1_sector_reg)
            SECTOR_1:
            begin
                p2_ta_next = half + half_trunc(x - z);
                p2_tb_next = p2_ta_next + z;
                p2_tc_next = p2_tb_next - x;
            end
            SECTOR_2:
            begin
                p2_tb_next = half + half_trunc(z + y);
                p2_ta_next = p2_tb_next - z;
                p2_tc_next = p2_ta_next - y;
            end
            SECTOR_3:
            begin
                p2_tb_next = half + half_trunc(x - y);
                p2_tc_next = p2_tb_next - x;
                p2_ta_next = p2_tc_next + y;
            end
            SECTOR_4:
            begin
                p2_tc_next = half + half_trunc(z - x);
                p2_tb_next = p2_tc_next + x;
                p2_ta_next = p2_tb_next - z;
            end
            SECTOR_5:
            begin
                p2_tc_next = half + half_trunc(-y - z);
                p2_ta_next = p2_tc_next + y;
                p2_tb_next = p2_ta_next + z;
            end
            default:
            begin
                p2_ta_next = half + half_trunc(y - x);
                p2_tc_next = p2_ta_next - y;
                p2_tb_next = p2_tc_next + x;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (p2_rdy && p1_valid_reg)
        begin
            p2_ta_reg     <= p2_ta_next;
            p2_tb_reg     <= p2_tb_next;
            p2_tc_reg     <= p2_tc_next;
            p2_sector_reg <= p1_sector_reg;
        end
    end

    // ------------------------------------------------------------------
    // P3: scale by compare_max, negative or zero time gives zero
    // ------------------------------------------------------------------
    function automatic logic [PW-1:0] scale_time(input logic signed [TW-1:0] t,
                                                 input logic [CMP_W-1:0]   cmax);
        logic [TW-2:0] tm;
        tm = t[TW-2:0];
        if (t[TW-1] || (t == '0))
            return '0;
        return PW'(tm) * PW'(cmax);
    endfunction

    logic [PW-1:0] p3_pa_reg, p3_pb_reg, p3_pc_reg;
    sector_t       p3_sector_reg;

    always_ff @(posedge clk)
    begin
        if (p3_rdy && p2_valid_reg)
        begin
            p3_pa_reg     <= scale_time(p2_ta_reg, cmax_reg);
            p3_pb_reg     <= scale_time(p2_tb_reg, cmax_reg);
            p3_pc_reg     <= scale_time(p2_tc_reg, cmax_reg);
            p3_sector_reg <= p2_sector_reg;
        end
    end

    // ------------------------------------------------------------------
    // P4: drop fraction, clamp to compare_max; output register
    // ------------------------------------------------------------------
    function automatic logic [CMP_W-1:0] clamp_cmp(input logic [PW-1:0]    p,
                                                   input logic [CMP_W-1:0] cmax);
        logic [CW-1:0] c;
        c = p[PW-1:FB];
        if (c > CW'(cmax))
            return cmax;
        return c[CMP_W-1:0];
    endfunction

    logic [CMP_W-1:0] p4_ca_reg, p4_cb_reg, p4_cc_reg;
    sector_t          p4_sector_reg;

    always_ff @(posedge clk)
    begin
        if (p4_rdy && p3_valid_reg)
        begin
            p4_ca_reg     <= clamp_cmp(p3_pa_reg, cmax_reg);
            p4_cb_reg     <= clamp_cmp(p3_pb_reg, cmax_reg);
            p4_cc_reg     <= clamp_cmp(p3_pc_reg, cmax_reg);
            p4_sector_reg <= p3_sector_reg;
        end
    end

    assign out_valid = p4_valid_reg;
    assign compare_a = p4_ca_reg;
    assign compare_b = p4_cb_reg;
    assign compare_c = p4_cc_reg;
    assign sector    = p4_sector_reg;

endmodule

@@ hdl/svpwm_divider.sv @@
// ============================================================================
// svpwm_divider
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module svpwm_divider
    import svpwm_pkg::*;
#(
    parameter int VW = VOLT_WIDTH_DEF,
    parameter int QB = FRAC_BITS_DEF + 3
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [NUM_LANES-1:0][VW-1:0]      in_rem,
    input  logic [NUM_LANES-1:0][QB-1:0]      in_lowq,
    input  logic [NUM_LANES-1:0]              in_neg,
    input  logic [NUM_LANES-1:0]              in_ovf,
    input  logic [VW-1:0]                     in_bus,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [NUM_LANES-1:0][QB-1:0]      out_quo,
    output logic [NUM_LANES-1:0]              out_neg,
    output logic [NUM_LANES-1:0]              out_ovf
);

    logic [NUM_LANES-1:0][VW-1:0] rem_reg  [QB];
    logic [NUM_LANES-1:0][QB-1:0] q_reg    [QB];
    logic [NUM_LANES-1:0]         neg_reg  [QB];
    logic [NUM_LANES-1:0]         ovf_reg  [QB];
    logic [VW-1:0]                bus_reg  [QB];
    logic                         valid_reg [QB];
    logic [QB:0]                  rdy;

    assign rdy[QB]   = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[QB-1];
    assign out_quo   = q_reg[QB-1];
    assign out_neg   = neg_reg[QB-1];
    assign out_ovf   = ovf_reg[QB-1];

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_stage
            logic [NUM_LANES-1:0][VW-1:0] rem_src;
            logic [NUM_LANES-1:0][QB-1:0] q_src;
            logic [NUM_LANES-1:0]         neg_src;
            logic [NUM_LANES-1:0]         ovf_src;
            logic [VW-1:0]                bus_src;
            logic                         v_src;
            logic [NUM_LANES-1:0][VW-1:0] rem_next;
            logic [NUM_LANES-1:0][QB-1:0] q_next;

            if (k == 0)
            begin : g_first
                assign rem_src = in_rem;
                assign q_src   = in_lowq;
                assign neg_src = in_neg;
                assign ovf_src = in_ovf;
                assign bus_src = in_bus;
                assign v_src   = in_valid;
            end
            else
            begin : g_next
                assign rem_src = rem_reg[k-1];
                assign q_src   = q_reg[k-1];
                assign neg_src = neg_reg[k-1];
                assign ovf_src = ovf_reg[k-1];
                assign bus_src = bus_reg[k-1];
                assign v_src   = valid_reg[k-1];
            end

            assign rdy[k] = !valid_reg[k] || rdy[k+1];

            always_comb
            begin
                logic [VW:0] t;
                logic [VW:0] diff;
                logic        ge;
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    // shift the next dividend bit into the partial remainder
                    t    = {rem_src[l], q_src[l][QB-1]};
                    diff = t - {1'b0, bus_src};
                    ge   = (t >= {1'b0, bus_src});
                    rem_next[l] = ge ? diff[VW-1:0] : t[VW-1:0];
                    q_next[l]   = {q_src[l][QB-2:0], ge};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (rdy[k])
                begin
                    valid_reg[k] <= v_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && v_src)
                begin
                    rem_reg[k] <= rem_next;
                    q_reg[k]   <= q_next;
                    neg_reg[k] <= neg_src;
                    ovf_reg[k] <= ovf_src;
                    bus_reg[k] <= bus_src;
                end
            end
        end
    endgenerate

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for svpwm_duty_calc_unit: directed corner samples, then
// random alpha/beta/bus items under several compare_max settings. Expected
// compare values and sectors come from a bit-true model in the bench, or from
// the table for known rows. Random stalls are applied on both sides.
// ============================================================================
module tb;
    import svpwm_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int VW          = VOLT_WIDTH_DEF;
    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int PIPE_DEPTH  = FRAC + 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam longint Q3_MAX  = (longint'(1) <<< (FRAC + 3)) - 1;

    typedef struct packed {
        logic [CMP_W-1:0]    ca;
        logic [CMP_W-1:0]    cb;
        logic [CMP_W-1:0]    cc;
        logic [SECTOR_W-1:0] sec;
    } duty_t;

    typedef struct packed {
        logic signed [VW-1:0] alpha;
        logic signed [VW-1:0] beta;
        logic [VW-1:0]        bus;
        logic                 known;
        duty_t                want;
    } sample_row_t;

    localparam int N_DIRECTED = 21;

    // Rows with known = 1 carry values that follow directly from the formulas:
    // the zero vector gives half duty on all legs; a saturated alpha on a 1-unit
    // bus pins one leg at full scale and the others at zero, or the reverse if negative.
    sample_row_t directed_rows [N_DIRECTED] = '{
        '{16'sd0,      16'sd0,      16'd1000,   1'b1, '{16'd2999, 16'd2999, 16'd2999, SECTOR_1}},
        '{16'sd0,      16'sd0,      16'd0,      1'b1, '{16'd2999, 16'd2999, 16'd2999, SECTOR_1}},
        '{16'sh7FFF,   16'sd0,      16'd1,      1'b1, '{16'd5999, 16'd0,    16'd0,    SECTOR_1}},
        '{16'sh8000,   16'sd0,      16'd1,      1'b1, '{16'd0,    16'd5999, 16'd5999, SECTOR_3}},
        '{16'sd500,    16'sd289,    16'd1000,   1'b0, '0},
        '{16'sd0,      16'sd500,    16'd1000,   1'b0, '0},
        '{-16'sd500,   16'sd289,    16'd1000,   1'b0, '0},
        '{-16'sd500,   -16'sd289,   16'd1000,   1'b0, '0},
        '{16'sd0,      -16'sd500,   16'd1000,   1'b0, '0},
        '{16'sd500,    -16'sd289,   16'd1000,   1'b0, '0},
        '{16'sd0,      16'sh7FFF,   16'd1,      1'b0, '0},
        '{16'sd0,      16'sh8000,   16'd1,      1'b0, '0},
        '{16'sh7FFF,   16'sh7FFF,   16'hFFFF,   1'b0, '0},
        '{16'sh8000,   16'sh8000,   16'hFFFF,   1'b0, '0},
        '{16'sh7FFF,   16'sh8000,   16'hFFFF,   1'b0, '0},
        '{16'sh8000,   16'sh7FFF,   16'hFFFF,   1'b0, '0},
        '{16'sd1,      16'sd0,      16'hFFFF,   1'b0, '0},
        '{16'sd0,      -16'sd1,     16'hFFFF,   1'b0, '0},
        '{16'sd500,    16'sd866,    16'd1000,   1'b0, '0},
        '{16'sh8000,   16'sh8000,   16'd0,      1'b0, '0},
        '{-16'sd1,     -16'sd1,     16'hFFFF,   1'b0, '0}
    };

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CMP_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic signed [VW-1:0] v_alpha     = '0;
    logic signed [VW-1:0] v_beta      = '0;
    logic [VW-1:0]        bus_voltage = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [CMP_W-1:0]     compare_a;
    logic [CMP_W-1:0]     compare_b;
    logic [CMP_W-1:0]     compare_c;
    logic [SECTOR_W-1:0]  sector;

    duty_t            duty_q [$];
    logic [CMP_W-1:0] full_scale = CMP_RESET;
    bit               steady     = 1'b0;
    int               error_count;
    int               results_checked;
    int               settings_used = 1;
    int               cycle_count;
    int               sector_hits [8];

    svpwm_duty_calc_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .v_alpha     (v_alpha),
        .v_beta      (v_beta),
        .bus_voltage (bus_voltage),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .compare_a   (compare_a),
        .compare_b   (compare_b),
        .compare_c   (compare_c),
        .sector      (sector)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic longint clamp_q3(longint v);
        if (v > Q3_MAX)
            return Q3_MAX;
        if (v < -Q3_MAX - 1)
            return -Q3_MAX - 1;
        return v;
    endfunction

    function automatic logic [CMP_W-1:0] on_time_to_count(longint t, logic [CMP_W-1:0] cmax);
        longint m;
        longint c;
        m = longint'(cmax);
        if (t <= 0)
            return '0;
        c = (t * m) >>> FRAC;
        if (c > m)
            c = m;
        return c[CMP_W-1:0];
    endfunction

    function automatic duty_t svpwm_duty(logic signed [VW-1:0] va, logic signed [VW-1:0] vb,
                                         logic [VW-1:0] vbus, logic [CMP_W-1:0] cmax);
        longint  a, b, bus, k3, bnum, anum, d1, d2, x, y, z, ta, tb, tc;
        longint  half;
        sector_t s;
        duty_t   r;
        a    = longint'(va);
        b    = longint'(vb);
        bus  = longint'(vbus);
        k3   = longint'(SQRT3_Q28);
        half = longint'(1) <<< (FRAC - 1);
        if (bus == 0)
            bus = 1;
        bnum = b * k3;
        anum = a * 3 * (longint'(1) <<< SQRT3_FRAC);
        d1   = bus <<< (SQRT3_FRAC - FRAC);
        d2   = bus <<< (SQRT3_FRAC + 1 - FRAC);
        x    = clamp_q3(bnum / d1);
        y    = clamp_q3((anum + bnum) / d2);
        z    = clamp_q3((bnum - anum) / d2);

        if (y < 0)
            s = (z < 0) ? SECTOR_5 : ((x < 0) ? SECTOR_4 : SECTOR_3);
        else
            s = (z > 0) ? SECTOR_2 : ((x < 0) ? SECTOR_6 : SECTOR_1);

        // halving of each sum truncates toward zero, same as integer divide
        case (s)
            SECTOR_1:
            begin
                ta = half + (x - z) / 2; tb = ta + z; tc = tb - x;
            end
            SECTOR_2:
            begin
                tb = half + (z + y) / 2; ta = tb - z; tc = ta - y;
            end
            SECTOR_3:
            begin
                tb = half + (x - y) / 2; tc = tb - x; ta = tc + y;
            end
            SECTOR_4:
            begin
                tc = half + (z - x) / 2; tb = tc + x; ta = tb - z;
            end
            SECTOR_5:
            begin
                tc = half + (-y - z) / 2; ta = tc + y; tb = ta + z;
            end
            default:
            begin
                ta = half + (y - x) / 2; tc = ta - y; tb = tc + x;
            end
        endcase

        r.ca  = on_time_to_count(ta, cmax);
        r.cb  = on_time_to_count(tb, cmax);
        r.cc  = on_time_to_count(tc, cmax);
        r.sec = s;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s on item %0d: got %0d expected %0d at %0t",
                 what, results_checked, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_sample(input logic signed [VW-1:0] a, input logic signed [VW-1:0] b,
                               input logic [VW-1:0] bus, input logic known, input duty_t want);
        if (!steady && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (!steady && $urandom_range(0, 99) < 33);
        end
        in_valid    <= 1'b1;
        v_alpha     <= a;
        v_beta      <= b;
        bus_voltage <= bus;
        do @(posedge clk); while (!in_ready);
        duty_q.push_back(known ? want : svpwm_duty(a, b, bus, full_scale));
    endtask

    task automatic random_samples(input int count);
        logic signed [VW-1:0] a;
        logic signed [VW-1:0] b;
        logic [VW-1:0]        bus;
        int                   mode;
        int                   amp;
        repeat (count)
        begin
            mode = $urandom_range(0, 9);
            bus  = VW'($urandom);
            a    = VW'($urandom);
            b    = VW'($urandom);
            if (mode < 6)
            begin
                // vectors in a realistic range for the bus voltage
                bus = VW'($urandom_range(16, 65535));
                amp = int'(bus) * 7 / 10;
                if (amp > 32767)
                    amp = 32767;
                a = VW'(int'($urandom_range(0, 2 * amp)) - amp);
                b = VW'(int'($urandom_range(0, 2 * amp)) - amp);
            end
            else if (mode == 8)
                bus = VW'($urandom_range(0, 15));
            else if (mode == 9)
            begin
                a = VW'(int'($urandom_range(0, 64)) - 32);
                b = VW'(int'($urandom_range(0, 64)) - 32);
            end
            send_sample(a, b, bus, 1'b0, '0);
        end
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (duty_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_full_scale(input logic [CMP_W-1:0] value);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        full_scale = value;
        settings_used++;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(0, 99) >= 33);
    end

    always @(posedge clk)
    begin
        duty_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (duty_q.size() == 0)
                flag_mismatch("unexpected item", longint'(compare_a), 0);
            else
            begin
                w = duty_q.pop_front();
                if (compare_a !== w.ca)
                    flag_mismatch("compare_a", longint'(compare_a), longint'(w.ca));
                if (compare_b !== w.cb)
                    flag_mismatch("compare_b", longint'(compare_b), longint'(w.cb));
                if (compare_c !== w.cc)
                    flag_mismatch("compare_c", longint'(compare_c), longint'(w.cc));
                if (sector !== w.sec)
                    flag_mismatch("sector", longint'(sector), longint'(w.sec));
                sector_hits[w.sec]++;
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items still pending",
                     cycle_count, duty_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].alpha, directed_rows[i].beta, directed_rows[i].bus,
                        directed_rows[i].known, directed_rows[i].want);
        random_samples(450);

        write_full_scale(16'hFFFF);
        random_samples(350);
        write_full_scale(16'd0);
        random_samples(200);
        write_full_scale(16'd1);
        random_samples(200);

        // back-to-back traffic with the sink always ready
        write_full_scale(CMP_W'($urandom));
        steady = 1'b1;
        random_samples(300);
        steady = 1'b0;
        write_full_scale(CMP_W'($urandom));
        random_samples(350);

        drain_pipeline();
        repeat (PIPE_DEPTH + 14) @(posedge clk);

        $display("checked %0d results across %0d compare_max settings", results_checked,
                 settings_used);
        $display("sector counts 1..6: %0d %0d %0d %0d %0d %0d", sector_hits[1],
                 sector_hits[2], sector_hits[3], sector_hits[4], sector_hits[5], sector_hits[6]);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
